// ----- design/ddmm_pkg.sv -----
// shared types, constants and the steering cut table for the motor mixer
// no dependencies; imported by ddmm_wheel and differential_drive_motor_mixer_top
package ddmm_pkg;

    // request kinds
    localparam logic [2:0] REQ_SET_MOTOR   = 3'd0;
    localparam logic [2:0] REQ_SET_POWER   = 3'd1;
    localparam logic [2:0] REQ_FORWARD     = 3'd2;
    localparam logic [2:0] REQ_BACKWARD    = 3'd3;
    localparam logic [2:0] REQ_STOP        = 3'd4;
    localparam logic [2:0] REQ_ESTOP       = 3'd5;
    localparam logic [2:0] REQ_CLEAR_ESTOP = 3'd6;

    // wheel ids for set_motor
    localparam logic [1:0] MOTOR_LEFT  = 2'd1;
    localparam logic [1:0] MOTOR_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_TRIM  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_TRIM = 2'd1;
    localparam logic [1:0] CFG_MAX_OUTPUT = 2'd2;

    // q8.8 percent
    localparam logic [14:0] FULL_SCALE  = 15'd25600;
    localparam logic [14:0] HALF_OFFSET = 15'd12800;

    // divide by 100 as multiply by ceil(2^29/100) and shift, exact below 2^22
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_100   = 23'd5368710;
    localparam logic [6:0]  ANGLE_MAX   = 7'd100;

    // one wheel request in sign and magnitude form, magnitude already clamped
    typedef struct packed {
        logic        neg;
        logic [14:0] mag;
    } wheel_cmd_t;

    // (100 - a) times the reciprocal, one entry per saturated angle
    function automatic logic [29:0] cut_factor(input logic [6:0] a);
        logic [6:0] keep;
        keep = ANGLE_MAX - a;
        return 30'({23'd0, keep} * {7'd0, RECIP_100});
    endfunction

endpackage

// ----- design/ddmm_wheel.sv -----
// per wheel output shaping: remap, trim, clamp and sign restore
// depends on ddmm_pkg
module ddmm_wheel
    import ddmm_pkg::*;
(
    input  wheel_cmd_t         cmd,
    input  logic signed [15:0] trim,
    input  logic [14:0]        max_out,
    output logic signed [15:0] speed
);

    logic signed [17:0] v_raw;
    logic [14:0]        v_clamp;
    logic [14:0]        v_lim;

    always_comb
    begin
        v_raw = $signed({4'b0000, cmd.mag[14:1]}) + $signed({3'b000, HALF_OFFSET})
              - $signed({{2{trim[15]}}, trim});
        priority if (v_raw < 18'sd0)
            v_clamp = 15'd0;
        else if (v_raw > $signed({3'b000, FULL_SCALE}))
            v_clamp = FULL_SCALE;
        else
            v_clamp = v_raw[14:0];
        v_lim = (v_clamp > max_out) ? max_out : v_clamp;
        // a zero request stays zero whatever the trim
        if (cmd.mag == 15'd0)
            speed = 16'sd0;
        else if (cmd.neg)
            speed = -$signed({1'b0, v_lim});
        else
            speed = $signed({1'b0, v_lim});
    end

endmodule

// ----- design/differential_drive_motor_mixer_top.sv -----
// top level of the two-wheel drive command mixer
// depends on ddmm_pkg and ddmm_wheel
//
// Each command item on the s_ side produces exactly one result item on the m_ side
// holding both applied wheel speeds and the stop and bad-motor flags. The block takes
// one item per clock cycle while the m_ side is ready; an item goes through an input
// register and a result register, moving into the result register once that register
// is empty or being read, and the result is taken from it when the m_ side is ready.
// Between these two registers lies a single-pass datapath:
// speed clamp, one steering multiply (table factor times magnitude, divide by 100 as
// reciprocal and shift) and the wheel trim and clamp logic, with the wheel state and
// the stop latch updated as the item moves into the result register. Configuration
// writes take effect at the next edge and should be made only while no item is in
// flight.
module differential_drive_motor_mixer_top
    import ddmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // speed_cmd [15:0], steer_angle [23:16]
    input  logic [4:0]  s_tuser,   // req_type [2:0], motor_select [4:3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // left_speed [15:0], right_speed [31:16]
    output logic [1:0]  m_tuser    // stop_latched [0], bad_motor [1]
);

    logic signed [15:0] left_trim_reg;
    logic signed [15:0] right_trim_reg;
    logic [14:0]        max_output_reg;

    logic               in_valid_reg;
    logic [23:0]        in_data_reg;
    logic [4:0]         in_user_reg;

    logic signed [15:0] left_drive_reg, left_drive_next;
    logic signed [15:0] right_drive_reg, right_drive_next;
    logic               halt_reg, halt_next;
    logic               bad_next;

    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic [1:0]         out_user_reg;

    logic               advance;
    logic               take;

    logic [2:0]         req;
    logic [1:0]         sel;
    logic signed [15:0] spd;
    logic signed [7:0]  ang;
    logic               spd_neg;
    logic [15:0]        spd_abs;
    logic [14:0]        spd_mag;
    logic [7:0]         ang_abs;
    logic [6:0]         ang_sat;
    logic               ang_pos;
    logic               ang_neg;
    logic [44:0]        cut_prod;
    logic [14:0]        cut_mag;
    wheel_cmd_t         plain_cmd;
    wheel_cmd_t         full_cmd;
    wheel_cmd_t         inner_cmd;
    wheel_cmd_t         left_cmd;
    wheel_cmd_t         right_cmd;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    assign advance  = !out_valid_reg || m_tready;
    assign take     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_trim_reg  <= 16'sd0;
            right_trim_reg <= 16'sd0;
            max_output_reg <= FULL_SCALE;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LEFT_TRIM:  left_trim_reg  <= $signed(cfg_wdata);
                CFG_RIGHT_TRIM: right_trim_reg <= $signed(cfg_wdata);
                CFG_MAX_OUTPUT: max_output_reg <= cfg_wdata[14:0];
                default:        ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_user_reg <= s_tuser;
        end
    end

    assign req = in_user_reg[2:0];
    assign sel = in_user_reg[4:3];
    assign spd = $signed(in_data_reg[15:0]);
    assign ang = $signed(in_data_reg[23:16]);

    always_comb
    begin
        spd_neg = spd[15];
        spd_abs = spd_neg ? 16'(-spd) : 16'(spd);
        spd_mag = (spd_abs > {1'b0, FULL_SCALE}) ? FULL_SCALE : spd_abs[14:0];
        ang_abs = ang[7] ? 8'(-ang) : 8'(ang);
        ang_sat = (ang_abs > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : ang_abs[6:0];
        ang_pos = !ang[7] && (ang != 8'sd0);
        ang_neg = ang[7];
    end

    // inside wheel cut, truncation toward zero on the magnitude
    assign cut_prod = {30'd0, spd_mag} * {15'd0, cut_factor(ang_sat)};
    assign cut_mag  = cut_prod[RECIP_SHIFT+14:RECIP_SHIFT];

    always_comb
    begin
        plain_cmd.neg = spd_neg;
        plain_cmd.mag = spd_mag;
        full_cmd      = plain_cmd;
        inner_cmd.neg = spd_neg;
        inner_cmd.mag = cut_mag;
        left_cmd      = plain_cmd;
        right_cmd     = plain_cmd;
        unique case (req)
            REQ_FORWARD:
            begin
                left_cmd  = ang_pos ? inner_cmd : full_cmd;
                right_cmd = ang_neg ? inner_cmd : full_cmd;
            end
            REQ_BACKWARD:
            begin
                full_cmd.neg  = !spd_neg;
                inner_cmd.neg = !spd_neg;
                left_cmd      = ang_pos ? full_cmd : inner_cmd;
                right_cmd     = ang_pos ? inner_cmd : full_cmd;
            end
            default:
            begin
                left_cmd  = plain_cmd;
                right_cmd = plain_cmd;
            end
        endcase
    end

    ddmm_wheel u_left_wheel
    (
        .cmd     (left_cmd),
        .trim    (left_trim_reg),
        .max_out (max_output_reg),
        .speed   (left_out)
    );

    ddmm_wheel u_right_wheel
    (
        .cmd     (right_cmd),
        .trim    (right_trim_reg),
        .max_out (max_output_reg),
        .speed   (right_out)
    );

    // command decode and wheel state update
    always_comb
    begin
        left_drive_next  = left_drive_reg;
        right_drive_next = right_drive_reg;
        halt_next        = halt_reg;
        bad_next         = 1'b0;
        unique case (req)
            REQ_SET_MOTOR:
            begin
                if (!halt_reg)
                begin
                    if (sel == MOTOR_LEFT)
                        left_drive_next = left_out;
                    else if (sel == MOTOR_RIGHT)
                        right_drive_next = right_out;
                    else
                        bad_next = 1'b1;
                end
            end
            REQ_SET_POWER, REQ_FORWARD, REQ_BACKWARD:
            begin
                if (!halt_reg)
                begin
                    left_drive_next  = left_out;
                    right_drive_next = right_out;
                end
            end
            REQ_STOP:
            begin
                left_drive_next  = 16'sd0;
                right_drive_next = 16'sd0;
            end
            REQ_ESTOP:
            begin
                halt_next        = 1'b1;
                left_drive_next  = 16'sd0;
                right_drive_next = 16'sd0;
            end
            REQ_CLEAR_ESTOP:
            begin
                halt_next = 1'b0;
            end
            default:
            begin
                halt_next = halt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_drive_reg  <= 16'sd0;
            right_drive_reg <= 16'sd0;
            halt_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                left_drive_reg  <= left_drive_next;
                right_drive_reg <= right_drive_next;
                halt_reg        <= halt_next;
            end
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= {right_drive_next, left_drive_next};
            out_user_reg <= {bad_next, halt_next};
        end
    end

`ifndef NO_ASSERTIONS
    // while the stop is latched both wheels read zero
    a_halt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("wheel speed nonzero while stop latched");

    // a bad wheel id is only flagged when drive commands are live
    a_bad_unlatched: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> !m_tuser[0])
        else $error("bad motor flagged while stop latched");

    // the applied left speed never exceeds full scale
    a_left_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= $signed({1'b0, FULL_SCALE}))
                  && ($signed(m_tdata[15:0]) >= -$signed({1'b0, FULL_SCALE})))
        else $error("left speed outside full scale");

    // a held input item keeps its slot until the result register frees up
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_data_reg))
        else $error("input stage item lost while stalled");
`endif

endmodule

// ----- tb/tb_differential_drive_motor_mixer_top.sv -----
// self-checking testbench for the two-wheel drive command mixer
// depends on ddmm_pkg and differential_drive_motor_mixer_top; directed table, then random phases
`timescale 1ns / 1ps

module tb_differential_drive_motor_mixer_top;
    import ddmm_pkg::*;

    localparam logic [2:0] REQ_UNUSED  = 3'd7;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         PHASE_ITEMS = 190;
    localparam int         DIR_ROWS    = 26;

    typedef struct packed {
        logic [2:0]         req;
        logic [1:0]         sel;
        logic signed [15:0] speed;
        logic signed [7:0]  angle;
        logic               typed;
        logic signed [15:0] left_w;
        logic signed [15:0] right_w;
        logic               stop_w;
        logic               bad_w;
    } cmd_row_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               stop;
        logic               bad;
    } drive_out_t;

    // typed rows hold the expected wheels, the rest go through the predictor
    localparam cmd_row_t DIRECTED [DIR_ROWS] = '{
        '{REQ_SET_POWER,   2'd0, 16'sd0,      8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_SET_MOTOR,   2'd0, 16'sd100,    8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b0, 1'b1},
        '{REQ_SET_MOTOR,   2'd3, 16'sd100,    8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b0, 1'b1},
        '{REQ_SET_MOTOR,   2'd1, 16'sd32767,  8'sd0,   1'b1, 16'sd25600,  16'sd0,      1'b0, 1'b0},
        '{REQ_SET_MOTOR,   2'd2, 16'h8000,    8'sd0,   1'b1, 16'sd25600,  -16'sd25600, 1'b0, 1'b0},
        '{REQ_SET_POWER,   2'd0, 16'sd1,      8'sd0,   1'b1, 16'sd12800,  16'sd12800,  1'b0, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd25600,  8'sd100, 1'b1, 16'sd0,      16'sd25600,  1'b0, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd25600, -8'sd100, 1'b1, 16'sd25600,  16'sd0,      1'b0, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd25600,  8'sd127, 1'b1, 16'sd0,      16'sd25600,  1'b0, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd12800,  8'h80,   1'b1, 16'sd19200,  16'sd0,      1'b0, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd12345,  8'sd45,  1'b0, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_BACKWARD,    2'd0, 16'sd25600,  8'sd0,   1'b1, -16'sd25600, -16'sd25600, 1'b0, 1'b0},
        '{REQ_BACKWARD,    2'd0, 16'sd20000,  8'sd30,  1'b0, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_BACKWARD,    2'd0, -16'sd7777, -8'sd60,  1'b0, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_STOP,        2'd0, 16'sd500,    8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_SET_POWER,   2'd0, -16'sd25600, 8'sd0,   1'b1, -16'sd25600, -16'sd25600, 1'b0, 1'b0},
        '{REQ_ESTOP,       2'd0, 16'sd0,      8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_SET_MOTOR,   2'd0, 16'sd9000,   8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_SET_POWER,   2'd0, 16'sd25600,  8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_FORWARD,     2'd0, 16'sd25600,  8'sd10,  1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_BACKWARD,    2'd0, 16'sd25600, -8'sd10,  1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_STOP,        2'd0, 16'sd0,      8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_UNUSED,      2'd1, 16'sd7000,   8'sd5,   1'b1, 16'sd0,      16'sd0,      1'b1, 1'b0},
        '{REQ_CLEAR_ESTOP, 2'd0, 16'sd0,      8'sd0,   1'b1, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_SET_POWER,   2'd0, 16'sd1000,   8'sd0,   1'b0, 16'sd0,      16'sd0,      1'b0, 1'b0},
        '{REQ_UNUSED,      2'd3, -16'sd1,    -8'sd1,   1'b0, 16'sd0,      16'sd0,      1'b0, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // speed_cmd [15:0], steer_angle [23:16]
    logic [4:0]  s_tuser;   // req_type [2:0], motor_select [4:3]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // left_speed [15:0], right_speed [31:16]
    logic [1:0]  m_tuser;   // stop_latched [0], bad_motor [1]

    // predictor copy of the wheel state and the registers
    int  pred_left;
    int  pred_right;
    bit  pred_halt;
    int  trim_left;
    int  trim_right;
    int  max_out;

    drive_out_t pending_drive[$];
    int         errors = 0;
    int         idle_cycles = 0;
    bit         calm;
    bit         hold_req;

    differential_drive_motor_mixer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_int(input int x, input int lo, input int hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // magnitude remap, trim, clamp to full scale and max_output, sign back on
    function automatic int wheel_level(input int raw, input int trim);
        int c;
        int mag;
        int v;
        c = clamp_int(raw, -25600, 25600);
        if (c == 0)
            return 0;
        mag = (c < 0) ? -c : c;
        v = clamp_int(mag / 2 + 12800 - trim, 0, 25600);
        if (v > max_out)
            v = max_out;
        return (c < 0) ? -v : v;
    endfunction

    // inside wheel slowdown, angle saturated at 100
    function automatic int steer_cut(input int speed, input int angle);
        int a;
        a = (angle < 0) ? -angle : angle;
        if (a > 100)
            a = 100;
        return (speed * (100 - a)) / 100;
    endfunction

    function automatic drive_out_t predict_drive(input cmd_row_t c);
        int         spd;
        int         ang;
        int         s;
        int         l;
        int         r;
        drive_out_t o;
        spd = int'(c.speed);
        ang = int'(c.angle);
        o.bad = 1'b0;
        case (c.req)
            REQ_SET_MOTOR:
                if (!pred_halt)
                begin
                    if (c.sel == MOTOR_LEFT)
                        pred_left = wheel_level(spd, trim_left);
                    else if (c.sel == MOTOR_RIGHT)
                        pred_right = wheel_level(spd, trim_right);
                    else
                        o.bad = 1'b1;
                end
            REQ_SET_POWER:
                if (!pred_halt)
                begin
                    pred_left  = wheel_level(spd, trim_left);
                    pred_right = wheel_level(spd, trim_right);
                end
            REQ_FORWARD:
                if (!pred_halt)
                begin
                    s = clamp_int(spd, -25600, 25600);
                    l = (ang > 0) ? steer_cut(s, ang) : s;
                    r = (ang < 0) ? steer_cut(s, ang) : s;
                    pred_left  = wheel_level(l, trim_left);
                    pred_right = wheel_level(r, trim_right);
                end
            REQ_BACKWARD:
                if (!pred_halt)
                begin
                    s = -clamp_int(spd, -25600, 25600);
                    l = (ang > 0) ? s : steer_cut(s, ang);
                    r = (ang > 0) ? steer_cut(s, ang) : s;
                    pred_left  = wheel_level(l, trim_left);
                    pred_right = wheel_level(r, trim_right);
                end
            REQ_STOP:
            begin
                pred_left  = 0;
                pred_right = 0;
            end
            REQ_ESTOP:
            begin
                pred_halt  = 1'b1;
                pred_left  = 0;
                pred_right = 0;
            end
            REQ_CLEAR_ESTOP:
                pred_halt = 1'b0;
            default:
                ;
        endcase
        o.left  = 16'(pred_left);
        o.right = 16'(pred_right);
        o.stop  = pred_halt;
        return o;
    endfunction

    function automatic logic signed [15:0] random_speed();
        int roll;
        roll = $urandom_range(99);
        if (roll < 30)
            return 16'($urandom);
        if (roll < 60)
            return 16'(int'($urandom_range(51200)) - 25600);
        if (roll < 80)
            return 16'(int'($urandom_range(600)) - 300);
        if (roll < 92)
        begin
            case ($urandom_range(5))
                0: return 16'h8000;
                1: return 16'sd32767;
                2: return 16'sd25600;
                3: return -16'sd25600;
                4: return 16'sd25601;
                default: return -16'sd25601;
            endcase
        end
        return 16'(int'($urandom_range(2)) - 1);
    endfunction

    function automatic logic signed [7:0] random_angle();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 8'(int'($urandom_range(200)) - 100);
        if (roll < 85)
            return 8'($urandom);
        case ($urandom_range(6))
            0: return 8'sd0;
            1: return 8'sd100;
            2: return -8'sd100;
            3: return 8'sd127;
            4: return 8'h80;
            5: return 8'sd1;
            default: return -8'sd1;
        endcase
    endfunction

    // mostly drive commands, with estop and clear mixed in so both halt states get traffic
    function automatic cmd_row_t random_cmd();
        cmd_row_t c;
        int       roll;
        c = '0;
        roll = $urandom_range(99);
        if (roll < 14)
            c.req = REQ_SET_MOTOR;
        else if (roll < 28)
            c.req = REQ_SET_POWER;
        else if (roll < 52)
            c.req = REQ_FORWARD;
        else if (roll < 76)
            c.req = REQ_BACKWARD;
        else if (roll < 83)
            c.req = REQ_STOP;
        else if (roll < 86)
            c.req = REQ_ESTOP;
        else if (roll < 97)
            c.req = REQ_CLEAR_ESTOP;
        else
            c.req = REQ_UNUSED;
        roll = $urandom_range(99);
        if (roll < 40)
            c.sel = MOTOR_LEFT;
        else if (roll < 80)
            c.sel = MOTOR_RIGHT;
        else
            c.sel = 2'($urandom_range(3));
        c.speed = random_speed();
        c.angle = random_angle();
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        errors++;
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    task automatic check_drive(input logic [31:0] data, input logic [1:0] user);
        drive_out_t want;
        if (pending_drive.size() == 0)
        begin
            report_mismatch("item with nothing pending, left_speed",
                            32'($signed(data[15:0])), 0);
            return;
        end
        want = pending_drive.pop_front();
        if (data[15:0] !== want.left)
            report_mismatch("left_speed", 32'($signed(data[15:0])), 32'(want.left));
        if (data[31:16] !== want.right)
            report_mismatch("right_speed", 32'($signed(data[31:16])), 32'(want.right));
        if (user[0] !== want.stop)
            report_mismatch("stop_latched", {31'd0, user[0]}, {31'd0, want.stop});
        if (user[1] !== want.bad)
            report_mismatch("bad_motor", {31'd0, user[1]}, {31'd0, want.bad});
    endtask

    task automatic send_cmd(input cmd_row_t c);
        drive_out_t want;
        while (!calm && $urandom_range(99) < 12)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.angle, c.speed};
        s_tuser  <= {c.sel, c.req};
        do
            @(posedge clk);
        while (!s_tready);
        want = predict_drive(c);
        if (c.typed)
        begin
            want.left  = c.left_w;
            want.right = c.right_w;
            want.stop  = c.stop_w;
            want.bad   = c.bad_w;
        end
        pending_drive.push_back(want);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_drive.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_LEFT_TRIM:  trim_left  = int'($signed(val));
            CFG_RIGHT_TRIM: trim_right = int'($signed(val));
            CFG_MAX_OUTPUT: max_out    = int'(val[14:0]);
            default: ;
        endcase
    endtask

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            check_drive(m_tdata, m_tuser);

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_differential_drive_motor_mixer_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: random stalls, a quiet stretch, and one long hold-off
    initial
    begin : receiver
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_tready <= calm || ($urandom_range(99) >= 12);
        end
    end

    initial
    begin : stimulus
        logic [15:0] lt;
        logic [15:0] rt;
        logic [14:0] mx;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_LEFT_TRIM;
        cfg_wdata   = 16'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 24'd0;
        s_tuser     = 5'd0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        pred_left   = 0;
        pred_right  = 0;
        pred_halt   = 1'b0;
        trim_left   = 0;
        trim_right  = 0;
        max_out     = 25600;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_cmd(DIRECTED[i]);
        wait_drain();

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:
                begin
                    lt = 16'd0;
                    rt = 16'd0;
                    mx = 15'd25600;
                end
                1:
                begin
                    lt = -16'sd25600;
                    rt = 16'sd25600;
                    mx = 15'd0;
                end
                2:
                begin
                    lt = 16'sd25600;
                    rt = -16'sd25600;
                    mx = 15'd12800;
                end
                3:
                begin
                    // trims at the ends of their 16-bit range, max_output above full scale
                    lt = 16'h8000;
                    rt = 16'h7fff;
                    mx = 15'h7fff;
                end
                4:
                begin
                    lt = 16'(int'($urandom_range(12800)) - 6400);
                    rt = 16'(int'($urandom_range(12800)) - 6400);
                    mx = 15'($urandom_range(25600));
                end
                5:
                begin
                    lt = 16'($urandom);
                    rt = 16'($urandom);
                    mx = 15'($urandom);
                end
                default:
                begin
                    lt = 16'(int'($urandom_range(6000)) - 3000);
                    rt = 16'(int'($urandom_range(6000)) - 3000);
                    mx = 15'd25600;
                end
            endcase
            write_reg(CFG_LEFT_TRIM, lt);
            write_reg(CFG_RIGHT_TRIM, rt);
            write_reg(CFG_MAX_OUTPUT, {1'b0, mx});
            cfg_wr_en <= 1'b0;
            calm     = (p == 0);
            hold_req = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_cmd(random_cmd());
            wait_drain();
        end

        calm = 1'b0;
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("tb_differential_drive_motor_mixer_top OK");
        else
            $display("tb_differential_drive_motor_mixer_top NOT OK");
        $finish;
    end

endmodule
